@@ rtl/umscd_pkg.sv @@
// Package for the serial motor and servo command decoder.
// Holds shared types, codes, constants and the angle group parser.
// No dependencies.
`default_nettype none
package umscd_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int PWM_FULL_SCALE    = 999;
    localparam int SERVO_LINE_LEN    = 13;
    localparam int ANGLE_MAX         = 180;

    // x / 255 as (x * DRIVE_RECIP) >> DRIVE_SHIFT, exact for x below 2^18
    localparam int DRIVE_SHIFT = 26;
    localparam int DRIVE_RECIP = (2**DRIVE_SHIFT + 254) / 255;
    // x / 180 as (x * SERVO_RECIP) >> SERVO_SHIFT, exact for x below 2^19
    localparam int SERVO_SHIFT = 27;
    localparam int SERVO_RECIP = (2**SERVO_SHIFT + ANGLE_MAX - 1) / ANGLE_MAX;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_V     = 8'h56;

    localparam logic [1:0] CFG_MOTOR_SPEED = 2'd0;
    localparam logic [1:0] CFG_PULSE_MIN   = 2'd1;
    localparam logic [1:0] CFG_PULSE_MAX   = 2'd2;

    localparam int TDATA_OUT_W = 96;

    typedef enum logic [3:0] {
        ST_TAKEN     = 4'd0,
        ST_IGNORED   = 4'd1,
        ST_FWD       = 4'd2,
        ST_BWD       = 4'd3,
        ST_LEFT      = 4'd4,
        ST_RIGHT     = 4'd5,
        ST_STOP      = 4'd6,
        ST_SERVO     = 4'd7,
        ST_ANGLE_ERR = 4'd8,
        ST_OVERFLOW  = 4'd9
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DRIVE1,
        S_DRIVE2,
        S_CMD,
        S_GROUP,
        S_MUL,
        S_DIV,
        S_WR,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       load_drive1;
        logic       load_drive2;
        logic       apply_cmd;
        logic       parse;
        logic       mul;
        logic       div;
        logic       wr;
        logic [1:0] idx;
        logic       set_status;
        status_t    code;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic decode_req;
        logic line_one;
        logic line_servo;
        logic angle_bad;
    } dp_stat_t;

    typedef struct packed {
        logic       neg;
        logic [9:0] mag;
    } group_val_t;

    // atoi over three characters; chars[7:0] is the first
    function automatic group_val_t parse_group(input logic [23:0] chars);
        group_val_t res;
        logic       in_digits;
        logic       done;
        logic [7:0] c;
        res       = '0;
        in_digits = 1'b0;
        done      = 1'b0;
        for (int p = 0; p < 3; p++)
        begin
            c = chars[8*p +: 8];
            if (!done)
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    res.mag   = 10'(res.mag * 10 + 10'(c - CH_ZERO));
                    in_digits = 1'b1;
                end
                else if (in_digits)
                    done = 1'b1;
                else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
                    ;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    res.neg   = (c == CH_MINUS);
                    in_digits = 1'b1;
                end
                else
                    done = 1'b1;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ rtl/umscd_ctrl.sv @@
// Controller of the command decoder: sequences byte handling, drive and servo math.
// Depends on umscd_pkg.
`default_nettype none
module umscd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire umscd_pkg::dp_stat_t stat,
    output umscd_pkg::dp_cmd_t      cmd
);
    import umscd_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                    state_next = stat.decode_req ? S_DECODE : S_EMIT;
            end
            S_DECODE:
            begin
                if (stat.line_one)
                    state_next = S_DRIVE1;
                else if (stat.line_servo)
                    state_next = S_GROUP;
                else
                    state_next = S_EMIT;
            end
            S_DRIVE1: state_next = S_DRIVE2;
            S_DRIVE2: state_next = S_CMD;
            S_CMD:    state_next = S_EMIT;
            S_GROUP:
            begin
                if (stat.angle_bad)
                    state_next = S_EMIT;
                else
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_DIV;
            S_DIV: state_next = S_WR;
            S_WR:
            begin
                idx_next   = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? S_EMIT : S_MUL;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.code       = ST_TAKEN;
        cmd.idx        = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE:   cmd.accept = accept;
            S_DECODE:
            begin
                if (!stat.line_one && !stat.line_servo)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_IGNORED;
                end
            end
            S_DRIVE1: cmd.load_drive1 = 1'b1;
            S_DRIVE2: cmd.load_drive2 = 1'b1;
            S_CMD:    cmd.apply_cmd   = 1'b1;
            S_GROUP:
            begin
                cmd.parse = 1'b1;
                if (stat.angle_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_ANGLE_ERR;
                end
            end
            S_MUL: cmd.mul = 1'b1;
            S_DIV: cmd.div = 1'b1;
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (idx_reg == 2'd3)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_SERVO;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/umscd_dp.sv @@
// Datapath of the command decoder: line capture, config, drive and servo math, output register.
// Depends on umscd_pkg.
`default_nettype none
module umscd_dp #(
    parameter int LINE_CAPACITY = umscd_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [10:0]                      cfg_data,
    input  wire umscd_pkg::dp_cmd_t               cmd,
    output umscd_pkg::dp_stat_t                   stat,
    output logic [umscd_pkg::TDATA_OUT_W-1:0]     out_data
);
    import umscd_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam int TXT_N = SERVO_LINE_LEN;

    logic [LEN_W-1:0]  len_reg;
    logic [7:0]        text_reg [TXT_N];
    logic              one_reg, servo_reg_f;
    status_t           status_reg;
    logic [7:0]        speed_reg;
    logic [10:0]       pmin_reg, pmax_reg;
    logic [9:0]        motor_reg [4];
    logic [10:0]       servo_reg [4];
    logic              led_reg;
    logic [17:0]       drv_prod_reg;
    logic [9:0]        drive_reg;
    logic [7:0]        angle_reg [4];
    logic signed [19:0] prod_reg;
    logic              neg_reg;
    logic [11:0]       quo_reg;
    logic [TDATA_OUT_W-1:0] out_reg;

    logic              is_nl;
    logic [23:0]       grp_chars;
    group_val_t        grp;
    logic signed [11:0] span;
    logic [18:0]       mag;
    logic [38:0]       quo_full;
    logic [36:0]       drv_full;
    logic signed [13:0] pulse;

    assign is_nl = (rx_byte == CH_NL);

    always_comb
    begin
        case (cmd.idx)
            2'd0:    grp_chars = {text_reg[3],  text_reg[2],  text_reg[1]};
            2'd1:    grp_chars = {text_reg[6],  text_reg[5],  text_reg[4]};
            2'd2:    grp_chars = {text_reg[9],  text_reg[8],  text_reg[7]};
            default: grp_chars = {text_reg[12], text_reg[11], text_reg[10]};
        endcase
    end

    assign grp  = parse_group(grp_chars);
    assign span = $signed({1'b0, pmax_reg}) - $signed({1'b0, pmin_reg});
    assign mag  = prod_reg[19] ? 19'(-prod_reg) : prod_reg[18:0];
    assign quo_full = 39'(mag) * 39'(SERVO_RECIP);
    assign drv_full = 37'(drv_prod_reg) * 37'(DRIVE_RECIP);
    assign pulse = $signed({3'b0, pmin_reg})
                 + (neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg}));

    assign stat.decode_req = is_nl && (len_reg != '0);
    assign stat.line_one   = one_reg;
    assign stat.line_servo = servo_reg_f;
    assign stat.angle_bad  = (grp.mag > 10'(ANGLE_MAX)) || (grp.neg && grp.mag != '0);

    // control state and visible values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            status_reg   <= ST_TAKEN;
            speed_reg    <= 8'd255;
            pmin_reg     <= 11'd70;
            pmax_reg     <= 11'd420;
            motor_reg[0] <= '0;
            motor_reg[1] <= '0;
            motor_reg[2] <= '0;
            motor_reg[3] <= '0;
            servo_reg[0] <= 11'd70;
            servo_reg[1] <= 11'd128;
            servo_reg[2] <= 11'd128;
            servo_reg[3] <= 11'd70;
            led_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MOTOR_SPEED: speed_reg <= cfg_data[7:0];
                    CFG_PULSE_MIN:   pmin_reg  <= cfg_data;
                    CFG_PULSE_MAX:   pmax_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                status_reg <= ST_TAKEN;
                if (is_nl)
                    len_reg <= '0;
                else if (len_reg < LEN_W'(LINE_CAPACITY - 1))
                begin
                    if (rx_byte != CH_CR)
                        len_reg <= len_reg + 1'b1;
                end
                else
                begin
                    len_reg    <= '0;
                    status_reg <= ST_OVERFLOW;
                end
            end
            if (cmd.set_status)
                status_reg <= cmd.code;
            if (cmd.apply_cmd)
            begin
                case (text_reg[0])
                    CH_F:
                    begin
                        motor_reg[0] <= drive_reg; motor_reg[1] <= '0;
                        motor_reg[2] <= drive_reg; motor_reg[3] <= '0;
                        led_reg <= !led_reg; status_reg <= ST_FWD;
                    end
                    CH_B:
                    begin
                        motor_reg[0] <= '0; motor_reg[1] <= drive_reg;
                        motor_reg[2] <= '0; motor_reg[3] <= drive_reg;
                        led_reg <= !led_reg; status_reg <= ST_BWD;
                    end
                    CH_L:
                    begin
                        motor_reg[0] <= drive_reg; motor_reg[1] <= '0;
                        motor_reg[2] <= '0;        motor_reg[3] <= '0;
                        led_reg <= !led_reg; status_reg <= ST_LEFT;
                    end
                    CH_R:
                    begin
                        motor_reg[0] <= '0; motor_reg[1] <= '0;
                        motor_reg[2] <= drive_reg; motor_reg[3] <= '0;
                        led_reg <= !led_reg; status_reg <= ST_RIGHT;
                    end
                    CH_S:
                    begin
                        motor_reg[0] <= '0; motor_reg[1] <= '0;
                        motor_reg[2] <= '0; motor_reg[3] <= '0;
                        status_reg <= ST_STOP;
                    end
                    default: status_reg <= ST_IGNORED;
                endcase
            end
            if (cmd.wr)
                servo_reg[cmd.idx] <= (pulse < 0) ? 11'd0 : pulse[10:0];
        end
    end

    // payload: line text, decode kind, arithmetic stages, output snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            one_reg     <= (len_reg == LEN_W'(1));
            servo_reg_f <= (len_reg == LEN_W'(SERVO_LINE_LEN)) && (text_reg[0] == CH_V);
            if (!is_nl && rx_byte != CH_CR && len_reg < LEN_W'(TXT_N))
                text_reg[len_reg[3:0]] <= rx_byte;
        end
        if (cmd.load_drive1)
            drv_prod_reg <= 18'(speed_reg * 18'(PWM_FULL_SCALE));
        if (cmd.load_drive2)
            drive_reg <= drv_full[DRIVE_SHIFT +: 10];
        if (cmd.parse)
            angle_reg[cmd.idx] <= grp.mag[7:0];
        if (cmd.mul)
            prod_reg <= $signed({1'b0, angle_reg[cmd.idx]}) * span;
        if (cmd.div)
        begin
            neg_reg <= prod_reg[19];
            quo_reg <= quo_full[SERVO_SHIFT +: 12];
        end
        if (cmd.emit)
            out_reg <= {7'b0, led_reg, servo_reg[3], servo_reg[2], servo_reg[1],
                        servo_reg[0], motor_reg[3], motor_reg[2], motor_reg[1],
                        motor_reg[0], status_reg};
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

@@ rtl/uart_motor_servo_command_decoder.sv @@
// Top level of the serial motor and servo command decoder.
// Depends on umscd_pkg, umscd_ctrl and umscd_dp.
//
//  channel   signals                      carries
//  s_        s_tvalid s_tready s_tdata    received character (rx_byte)
//  m_        m_tvalid m_tready m_tdata    status plus motor, servo and LED values
//  cfg_      cfg_we cfg_index cfg_data    motor_speed, servo_pulse_min, servo_pulse_max
//
// One item is taken at a time. An ordinary character goes straight to its result;
// a drive line adds decode, two drive steps and a command step; a servo line adds
// decode, four parse steps, then multiply, reciprocal and write for each servo.
// Reset clears the line, zeroes the motors and loads the default servo pulses.
// A stalled result holds in the output register; the next item waits behind it.
`default_nettype none
module uart_motor_servo_command_decoder #(
    parameter int LINE_CAPACITY = umscd_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] status, [13:4] motor_a_fwd, [23:14] motor_a_rev, [33:24] motor_b_fwd,
    // [43:34] motor_b_rev, [54:44] servo_one, [65:55] servo_two,
    // [76:66] servo_three, [87:77] servo_four, [88] led, rest zero
    output logic [umscd_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [10:0]                   cfg_data
);
    import umscd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: takes the item, walks the decode steps, loads the result
    umscd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // line capture, arithmetic and held outputs
    umscd_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire

@@ rtl/umscd_checker.sv @@
// Port-level checker for the command decoder, bound to the top level.
// Depends on uart_motor_servo_command_decoder.
`default_nettype none
module umscd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // one item at a time: after an accept the input side closes
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9))
        else $error("status out of range");

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3:0] == 4'd6) |-> (m_tdata[43:4] == 40'd0))
        else $error("stop left a motor running");

    a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:4] <= 10'd999 && m_tdata[33:24] <= 10'd999))
        else $error("motor compare above full scale");

endmodule

bind uart_motor_servo_command_decoder umscd_checker u_umscd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
